FILE: rtl/core/bpc_pkg.sv
// shared types, constants and helpers for the barometric compensation block
// no dependencies
`default_nettype none

package bpc_pkg;

  localparam int unsigned DW = 32;

  localparam logic [DW-1:0] TEMP_BIAS  = 32'd4000;
  localparam logic [DW-1:0] P_SQ_GAIN  = 32'd3038;
  localparam logic [DW-1:0] P_LIN_GAIN = 32'd7357;
  localparam logic [DW-1:0] P_OFFSET   = 32'd3791;
  localparam logic [DW-1:0] P_SCALE    = 32'd50000;
  localparam logic [DW-1:0] B4_BIAS    = 32'd32768;

  typedef enum logic [2:0] {
    REG_TEMP_GAIN_OFFSET = 3'd0,
    REG_TEMP_CURVE       = 3'd1,
    REG_PRES_OFFSET      = 3'd2,
    REG_PRES_SENSE       = 3'd3,
    REG_PRES_SQUARE      = 3'd4,
    REG_OVERSAMPLING     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [27:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_fault;
  } out_t;

  typedef struct packed {
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] mc;
    logic [15:0] md;
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [1:0]  oss;
  } coef_t;

  typedef struct packed {
    logic [DW-1:0] b5;
    logic [18:0]   up;
    logic          fault;
  } tmp_res_t;

  function automatic logic [DW-1:0] sx16(input logic [15:0] v);
    return {{(DW-16){v[15]}}, v};
  endfunction

  function automatic logic [DW-1:0] asr(input logic [DW-1:0] v, input int unsigned n);
    return DW'($signed(v) >>> n);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bpc_udiv.sv
// pipelined unsigned divider, one quotient bit per stage
// depends on bpc_pkg
`default_nettype none

module bpc_udiv #(
  parameter int unsigned SbW = 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   vld_i,
  input  wire logic [bpc_pkg::DW-1:0] num_i,
  input  wire logic [bpc_pkg::DW-1:0] den_i,
  input  wire logic [SbW-1:0]         sb_i,
  output logic                        vld_o,
  output logic [bpc_pkg::DW-1:0]      quo_o,
  output logic [SbW-1:0]              sb_o
);
  import bpc_pkg::*;

  logic [DW-1:0]  rem_q [DW];
  logic [DW-1:0]  num_q [DW];
  logic [DW-1:0]  quo_q [DW];
  logic [DW-1:0]  den_q [DW];
  logic [SbW-1:0] sb_q  [DW];
  logic [DW-1:0]  vld_q;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [DW-1:0]  rem_in, num_in, quo_in, den_in;
    logic [SbW-1:0] sb_in;
    logic           vld_in;
    logic [DW:0]    trial;
    logic           ge;
    logic [DW:0]    diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign num_in = num_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
      assign sb_in  = sb_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    // restoring step
    assign trial = {rem_in, num_in[DW-1]};
    assign ge    = (trial >= {1'b0, den_in});
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_q[i] <= {num_in[DW-2:0], 1'b0};
      quo_q[i] <= {quo_in[DW-2:0], ge};
      den_q[i] <= den_in;
      sb_q[i]  <= sb_in;
    end
  end

  assign vld_o = vld_q[DW-1];
  assign quo_o = quo_q[DW-1];
  assign sb_o  = sb_q[DW-1];

endmodule

`default_nettype wire

FILE: rtl/core/bpc_temp.sv
// temperature path: raw temperature to correction term b5
// depends on bpc_pkg and bpc_udiv
`default_nettype none

module bpc_temp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire bpc_pkg::in_t      in_i,
  input  wire bpc_pkg::coef_t    coef_i,
  output logic                   vld_o,
  output bpc_pkg::tmp_res_t      res_o
);
  import bpc_pkg::*;

  localparam int unsigned SbW = DW + 19 + 2;

  logic          vld1_q;
  logic [DW-1:0] prod1_q;
  logic [18:0]   up1_q;

  logic [DW-1:0] x1, den, num, ua, ub;
  logic          neg, zero;
  logic          dvld;
  logic [DW-1:0] quo, x2;
  logic [SbW-1:0] sb_in, sb_out;
  logic [DW-1:0] sx1;
  logic [18:0]   sup;
  logic          sneg, szero;

  logic          vld_q;
  tmp_res_t      res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= ({16'd0, in_i.raw_temperature} - {16'd0, coef_i.ac6}) * {16'd0, coef_i.ac5};
    up1_q   <= in_i.raw_pressure;
  end

  always_comb begin
    x1    = asr(prod1_q, 15);
    den   = x1 + sx16(coef_i.md);
    num   = sx16(coef_i.mc) << 11;
    ua    = num[DW-1] ? (~num + 1'b1) : num;
    ub    = den[DW-1] ? (~den + 1'b1) : den;
    neg   = num[DW-1] ^ den[DW-1];
    zero  = (den == '0);
    sb_in = {x1, up1_q, neg, zero};
  end

  bpc_udiv #(.SbW(SbW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld1_q),
    .num_i  (ua),
    .den_i  (ub),
    .sb_i   (sb_in),
    .vld_o  (dvld),
    .quo_o  (quo),
    .sb_o   (sb_out)
  );

  always_comb begin
    {sx1, sup, sneg, szero} = sb_out;
    if (szero) begin
      x2 = '0;
    end else if (sneg) begin
      x2 = ~quo + 1'b1;
    end else begin
      x2 = quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= dvld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.b5    <= sx1 + x2;
    res_q.up    <= sup;
    res_q.fault <= szero;
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/bpc_pres.sv
// pressure path: b5 and raw pressure to compensated pressure and temperature
// depends on bpc_pkg and bpc_udiv
`default_nettype none

module bpc_pres (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire bpc_pkg::tmp_res_t tmp_i,
  input  wire bpc_pkg::coef_t    coef_i,
  output logic                   vld_o,
  output bpc_pkg::out_t          res_o
);
  import bpc_pkg::*;

  localparam int unsigned SbW = 28 + 3;

  // valid chain for the stages around the divider
  logic [5:0] vld_a_q;
  logic [3:0] vld_b_q;

  // temperature and fault carried through every front stage, raw pressure up to stage 5
  logic [27:0] t_q  [6];
  logic [18:0] up_q [4];
  logic        f_q  [6];

  logic [DW-1:0] b6, sqp_q, a2b6_q, a3b6_q;
  logic [DW-1:0] sq_q, x2a_q, x1b_q;
  logic [DW-1:0] b2sq_q, b1sq_q, x2a3_q, x1b3_q;
  logic [DW-1:0] x3, v, nv, b3, x3b;
  logic [DW-1:0] b3_q, x3b_q;
  logic [DW-1:0] b4p_q, b7d_q;
  logic [DW-1:0] b4_q, b7_q;

  logic          zero, dbl;
  logic [DW-1:0] dnum;
  logic          dvld;
  logic [DW-1:0] quo;
  logic [SbW-1:0] sb_in, sb_out;
  logic [27:0]   st;
  logic          sf, szero, sdbl;

  logic [DW-1:0] p7_q, a8;
  logic [27:0]   t7_q, t8_q, t9_q;
  logic          f7_q, f8_q, f9_q;
  logic [DW-1:0] m1_q, m2_q, p8_q;
  logic [DW-1:0] m3_q, x2_q, p9_q;
  out_t          res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
    end else begin
      vld_a_q <= {vld_a_q[4:0], vld_i};
      vld_b_q <= {vld_b_q[2:0], dvld};
    end
  end

  assign b6 = tmp_i.b5 - TEMP_BIAS;

  always_comb begin
    x3   = asr(b2sq_q, 11) + x2a3_q;
    v    = (((sx16(coef_i.ac1) << 2) + x3) << coef_i.oss) + 32'd2;
    nv   = ~v + 1'b1;
    // truncating divide by four
    b3   = v[DW-1] ? ~(nv >> 2) + 1'b1 : (v >> 2);
    x3b  = asr(x1b3_q + asr(b1sq_q, 16) + 32'd2, 2);
  end

  always_ff @(posedge clk_i) begin
    // stage 1: squares and linear products of b6
    t_q[0]  <= 28'(asr(tmp_i.b5 + 32'd8, 4));
    up_q[0] <= tmp_i.up;
    f_q[0]  <= tmp_i.fault;
    sqp_q   <= b6 * b6;
    a2b6_q  <= sx16(coef_i.ac2) * b6;
    a3b6_q  <= sx16(coef_i.ac3) * b6;
    // stage 2
    sq_q    <= asr(sqp_q, 12);
    x2a_q   <= asr(a2b6_q, 11);
    x1b_q   <= asr(a3b6_q, 13);
    // stage 3
    b2sq_q  <= sx16(coef_i.b2) * sq_q;
    b1sq_q  <= sx16(coef_i.b1) * sq_q;
    x2a3_q  <= x2a_q;
    x1b3_q  <= x1b_q;
    // stage 4: b3 and the b4 correction
    b3_q    <= b3;
    x3b_q   <= x3b;
    // stage 5
    b4p_q   <= {16'd0, coef_i.ac4} * (x3b_q + B4_BIAS);
    b7d_q   <= {13'd0, up_q[3]} - b3_q;
    // stage 6
    b4_q    <= b4p_q >> 15;
    b7_q    <= b7d_q * (P_SCALE >> coef_i.oss);
  end

  for (genvar i = 1; i < 6; i++) begin : g_carry
    always_ff @(posedge clk_i) begin
      t_q[i] <= t_q[i-1];
      f_q[i] <= f_q[i-1];
    end
  end

  for (genvar i = 1; i < 4; i++) begin : g_up
    always_ff @(posedge clk_i) begin
      up_q[i] <= up_q[i-1];
    end
  end

  // keep the numerator inside 32 bits: double before or after the divide
  always_comb begin
    zero  = (b4_q == '0);
    dbl   = b7_q[DW-1];
    dnum  = dbl ? b7_q : {b7_q[DW-2:0], 1'b0};
    sb_in = {t_q[5], f_q[5], zero, dbl};
  end

  bpc_udiv #(.SbW(SbW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_a_q[5]),
    .num_i  (dnum),
    .den_i  (b4_q),
    .sb_i   (sb_in),
    .vld_o  (dvld),
    .quo_o  (quo),
    .sb_o   (sb_out)
  );

  assign {st, sf, szero, sdbl} = sb_out;
  assign a8 = asr(p7_q, 8);

  always_ff @(posedge clk_i) begin
    // stage 7: raw pressure
    if (szero) begin
      p7_q <= '0;
    end else if (sdbl) begin
      p7_q <= {quo[DW-2:0], 1'b0};
    end else begin
      p7_q <= quo;
    end
    t7_q <= st;
    f7_q <= sf | szero;
    // stage 8
    m1_q <= a8 * a8;
    m2_q <= (~P_LIN_GAIN + 1'b1) * p7_q;
    p8_q <= p7_q;
    t8_q <= t7_q;
    f8_q <= f7_q;
    // stage 9
    m3_q <= m1_q * P_SQ_GAIN;
    x2_q <= asr(m2_q, 16);
    p9_q <= p8_q;
    t9_q <= t8_q;
    f9_q <= f8_q;
    // stage 10: final correction
    res_q.pressure_pa        <= p9_q + asr(asr(m3_q, 16) + x2_q + P_OFFSET, 4);
    res_q.temperature_tenths <= t9_q;
    res_q.divide_fault       <= f9_q;
  end

  assign vld_o = vld_b_q[3];
  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/baro_temp_pressure_compensation.sv
// top level of the barometric temperature and pressure compensation block
// depends on bpc_pkg, bpc_temp, bpc_pres (and through them bpc_udiv)
`default_nettype none

// One sample pair (raw temperature, aligned raw pressure) is taken on every
// clock edge where start_i is high; busy_o is never raised, so a new pair may
// follow in the very next cycle and any number may be in flight. Each pair
// gives exactly one result, shown on res_o for one cycle with res_valid_o
// high; results leave in the order the pairs came. The path runs through
// two 32-stage dividers, one in the temperature path and one in the pressure
// path, with the multiplier stages around them. The receiver cannot hold a
// result off, so nothing in the datapath ever stalls. The user must write the
// calibration registers over the APB port only while no transfer is in
// flight; the block itself does not enforce it. All stages read them directly.
module baro_temp_pressure_compensation (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // sample channel
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire bpc_pkg::in_t  in_i,
  // result channel
  output logic               res_valid_o,
  output bpc_pkg::out_t      res_o,
  // configuration port
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bpc_pkg::*;

  // calibration registers
  logic [31:0] tgo_q, tcv_q, pof_q, pse_q, psq_q;
  logic [1:0]  oss_q;
  logic        wr_en;
  reg_idx_e    widx;
  coef_t       coef;

  logic     tvld;
  tmp_res_t tres;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;
  assign widx   = reg_idx_e'(paddr[4:2]);

  // writes beyond the list fall through to no register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgo_q <= '0;
      tcv_q <= '0;
      pof_q <= '0;
      pse_q <= '0;
      psq_q <= '0;
      oss_q <= 2'd3;
    end else if (wr_en) begin
      case (widx)
        REG_TEMP_GAIN_OFFSET: tgo_q <= pwdata;
        REG_TEMP_CURVE:       tcv_q <= pwdata;
        REG_PRES_OFFSET:      pof_q <= pwdata;
        REG_PRES_SENSE:       pse_q <= pwdata;
        REG_PRES_SQUARE:      psq_q <= pwdata;
        REG_OVERSAMPLING:     oss_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (widx)
      REG_TEMP_GAIN_OFFSET: prdata = tgo_q;
      REG_TEMP_CURVE:       prdata = tcv_q;
      REG_PRES_OFFSET:      prdata = pof_q;
      REG_PRES_SENSE:       prdata = pse_q;
      REG_PRES_SQUARE:      prdata = psq_q;
      REG_OVERSAMPLING:     prdata = {30'd0, oss_q};
      default:              prdata = '0;
    endcase
  end

  // unpack the coefficient pairs
  assign coef.ac5 = tgo_q[31:16];
  assign coef.ac6 = tgo_q[15:0];
  assign coef.mc  = tcv_q[31:16];
  assign coef.md  = tcv_q[15:0];
  assign coef.ac1 = pof_q[31:16];
  assign coef.ac2 = pof_q[15:0];
  assign coef.ac3 = pse_q[31:16];
  assign coef.ac4 = pse_q[15:0];
  assign coef.b1  = psq_q[31:16];
  assign coef.b2  = psq_q[15:0];
  assign coef.oss = oss_q;

  // temperature path, ends in b5
  bpc_temp u_temp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i),
    .in_i   (in_i),
    .coef_i (coef),
    .vld_o  (tvld),
    .res_o  (tres)
  );

  // pressure path, last stage is the output register
  bpc_pres u_pres (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (tvld),
    .tmp_i  (tres),
    .coef_i (coef),
    .vld_o  (res_valid_o),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
